>>> design/range_max_prefix_sum_table_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion wrappers; empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef RANGE_MAX_PREFIX_SUM_TABLE_TOP_MACROS_SVH
`define RANGE_MAX_PREFIX_SUM_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RMPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmps assertion failed");
`define RMPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmps assertion failed");
`else
`define RMPS_ASSERT_IMP(lbl, ante, cons)
`define RMPS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> design/rmps_pkg.sv
// ----------------------------------------------------------------------------
// rmps_pkg
// Widths and codes shared by the range max prefix sum table.
// ----------------------------------------------------------------------------
package rmps_pkg;
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = 11;
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 48;
  localparam int OUT_W  = 41;
  localparam logic [IDX_W-1:0] LEN_MAX   = IDX_W'(DEPTH);
  localparam logic [IDX_W-1:0] LEN_RESET = 11'd1024;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;
endpackage

>>> design/range_max_prefix_sum_table_top.sv
// ----------------------------------------------------------------------------
// range_max_prefix_sum_table_top
// Element store plus stored prefix sums, swept by one add/compare unit.
// ----------------------------------------------------------------------------
// After reset the block clears both memories with busy high. A write
// outside the length is dropped with busy staying low; a write that leaves
// the value unchanged ends after the element write; any other write then
// updates the prefix entries from first to L, one prefix entry updated per
// cycle through the read-modify-write path of the prefix memory
// (L = effective length). A query, after clamping, first reads the prefix
// before the range when first > 1, then sweeps first to last, one prefix
// entry read per cycle; an empty range needs no sweep. The result appears
// on out_best_prefix for exactly one cycle with out_valid, the first cycle
// with busy low after the item (the cycle after the transfer for an empty
// range); it cannot be stalled, so the receiver must take it.
module range_max_prefix_sum_table_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_opcode,
  input  logic [rmps_pkg::IDX_W-1:0]   in_first_index,
  input  logic [rmps_pkg::IDX_W-1:0]   in_last_index,
  input  logic signed [rmps_pkg::VAL_W-1:0] in_new_value,
  output logic                         out_valid,
  output logic [rmps_pkg::OUT_W-1:0]   out_best_prefix,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rmps_pkg::IDX_W-1:0]   cfg_used_length
);
`include "range_max_prefix_sum_table_top_macros.svh"

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_EWR  = 3'd2;
  localparam logic [2:0] S_QBW  = 3'd3;
  localparam logic [2:0] S_SWP  = 3'd4;

  localparam int AW = rmps_pkg::ADDR_W;
  localparam int IW = rmps_pkg::IDX_W;
  localparam int SW = rmps_pkg::SUM_W;
  localparam int OW = rmps_pkg::OUT_W;
  localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW:0]   OUT_SAT = (SW+1)'({OW{1'b1}});

  logic [2:0]  state_r, state_nxt;
  logic [IW-1:0] used_length_r;
  logic [IW-1:0] clr_r, clr_nxt;
  logic        op_r, op_nxt;
  logic [IW-1:0] first_r, first_nxt;
  logic [IW-1:0] len_r, len_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [IW-1:0] end_r, end_nxt;
  logic signed [rmps_pkg::VAL_W-1:0] val_r, val_nxt;
  logic signed [SW-1:0] d_r, d_nxt;
  logic signed [SW-1:0] base_r, base_nxt;
  logic signed [SW-1:0] max_r, max_nxt;
  logic        pv_r, pv_nxt;
  logic [AW-1:0] pa_r, pa_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [OW-1:0] out_best_r, out_best_nxt;

  logic          e_we, p_we;
  logic [AW-1:0] e_waddr, e_raddr, p_waddr, p_raddr;
  logic [rmps_pkg::VAL_W-1:0] e_wdata, e_rdata;
  logic [SW-1:0] p_wdata, p_rdata;

  logic          accept;
  logic [IW-1:0] len_now, fq, lq;
  logic signed [rmps_pkg::VAL_W:0] diff33;
  logic signed [SW:0] res_diff;

  rmps_ram #(.WIDTH(rmps_pkg::VAL_W), .DEPTH(rmps_pkg::DEPTH)) u_elem (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  rmps_ram #(.WIDTH(SW), .DEPTH(rmps_pkg::DEPTH)) u_pref (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  assign busy            = (state_r != S_IDLE);
  assign accept          = start && !busy;
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_best_prefix = out_best_r;

  assign len_now = (used_length_r > rmps_pkg::LEN_MAX) ? rmps_pkg::LEN_MAX : used_length_r;
  assign fq      = (in_first_index == '0) ? IW'(1) : in_first_index;
  assign lq      = (in_last_index > len_now) ? len_now : in_last_index;
  assign diff33  = {val_r[rmps_pkg::VAL_W-1], val_r}
                 - {e_rdata[rmps_pkg::VAL_W-1], e_rdata};
  assign res_diff = {max_r[SW-1], max_r} - {base_r[SW-1], base_r};

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    first_nxt     = first_r;
    len_nxt       = len_r;
    k_nxt         = k_r;
    end_nxt       = end_r;
    val_nxt       = val_r;
    d_nxt         = d_r;
    base_nxt      = base_r;
    max_nxt       = max_r;
    pv_nxt        = 1'b0;
    pa_nxt        = pa_r;
    out_valid_nxt = 1'b0;
    out_best_nxt  = out_best_r;
    e_we    = 1'b0;
    e_waddr = first_r[AW-1:0] - AW'(1);
    e_wdata = val_r;
    e_raddr = in_first_index[AW-1:0] - AW'(1);
    p_we    = 1'b0;
    p_waddr = pa_r;
    p_wdata = p_rdata + d_r;
    p_raddr = k_r[AW-1:0] - AW'(1);

    case (state_r)
      S_CLR: begin
        e_we    = 1'b1;
        e_waddr = clr_r[AW-1:0];
        e_wdata = '0;
        p_we    = 1'b1;
        p_waddr = clr_r[AW-1:0];
        p_wdata = '0;
        clr_nxt = clr_r + IW'(1);
        if (clr_r == IW'(rmps_pkg::DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        // base read for queries: prefix just before the range
        p_raddr = fq[AW-1:0] - AW'(2);
        if (accept) begin
          op_nxt    = in_opcode;
          first_nxt = in_first_index;
          len_nxt   = len_now;
          val_nxt   = in_new_value;
          if (in_opcode == rmps_pkg::OP_WRITE) begin
            if (in_first_index != '0 && in_first_index <= len_now) begin
              state_nxt = S_EWR;
            end
          end else if (len_now == '0 || fq > lq) begin
            out_valid_nxt = 1'b1;
            out_best_nxt  = '0;
          end else begin
            k_nxt    = fq;
            end_nxt  = lq;
            max_nxt  = SUM_MIN;
            base_nxt = '0;
            state_nxt = (fq > IW'(1)) ? S_QBW : S_SWP;
          end
        end
      end
      S_EWR: begin
        e_we  = 1'b1;
        d_nxt = SW'(diff33);
        if (diff33 == '0) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt     = first_r;
          end_nxt   = len_r;
          state_nxt = S_SWP;
        end
      end
      S_QBW: begin
        base_nxt  = p_rdata;
        state_nxt = S_SWP;
      end
      S_SWP: begin
        if (k_r <= end_r) begin
          pv_nxt = 1'b1;
          pa_nxt = k_r[AW-1:0] - AW'(1);
          k_nxt  = k_r + IW'(1);
        end
        if (pv_r) begin
          if (op_r == rmps_pkg::OP_WRITE) begin
            p_we = 1'b1;
          end else if ($signed(p_rdata) > max_r) begin
            max_nxt = p_rdata;
          end
        end
        if (k_r > end_r && !pv_r) begin
          state_nxt = S_IDLE;
          if (op_r == rmps_pkg::OP_QUERY) begin
            out_valid_nxt = 1'b1;
            if (res_diff[SW] || (res_diff == '0)) begin
              out_best_nxt = '0;
            end else if (res_diff > OUT_SAT) begin
              out_best_nxt = {OW{1'b1}};
            end else begin
              out_best_nxt = res_diff[OW-1:0];
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      clr_r         <= '0;
      used_length_r <= rmps_pkg::LEN_RESET;
      pv_r          <= 1'b0;
      out_valid_r   <= 1'b0;
      op_r          <= rmps_pkg::OP_WRITE;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
      if (cfg_valid && cfg_ready) begin
        used_length_r <= cfg_used_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    first_r    <= first_nxt;
    len_r      <= len_nxt;
    k_r        <= k_nxt;
    end_r      <= end_nxt;
    val_r      <= val_nxt;
    d_r        <= d_nxt;
    base_r     <= base_nxt;
    max_r      <= max_nxt;
    pa_r       <= pa_nxt;
    out_best_r <= out_best_nxt;
  end

  `RMPS_ASSERT_IMP(a_result_only_query, out_valid_r, op_r == rmps_pkg::OP_QUERY)
  `RMPS_ASSERT_IMP(a_pending_in_sweep, pv_r, state_r == S_SWP)
  `RMPS_ASSERT_IMP(a_pref_write_src, p_we && state_r != S_CLR, op_r == rmps_pkg::OP_WRITE && pv_r)
  `RMPS_ASSERT_NXT(a_sweep_result, state_r == S_SWP && k_r > end_r && !pv_r && op_r == rmps_pkg::OP_QUERY, out_valid_r)
endmodule

>>> design/rmps_ram.sv
// ----------------------------------------------------------------------------
// rmps_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rmps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sim/range_max_prefix_sum_table_top_tb.sv
// ----------------------------------------------------------------------------
// range_max_prefix_sum_table_top_tb
// Drives element writes and range queries into the prefix sum table; checks
// every query answer against a flat prefix-sum predictor or a known result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module range_max_prefix_sum_table_top_tb;

  localparam logic [rmps_pkg::OUT_W-1:0] BEST_SAT = '1;

  typedef struct {
    logic                       op;
    logic [rmps_pkg::IDX_W-1:0] first;
    logic [rmps_pkg::IDX_W-1:0] last;
    logic [rmps_pkg::VAL_W-1:0] value;
    bit                         known;
    logic [rmps_pkg::OUT_W-1:0] best;
  } stim_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic                              in_opcode = rmps_pkg::OP_WRITE;
  logic [rmps_pkg::IDX_W-1:0]        in_first_index = '0;
  logic [rmps_pkg::IDX_W-1:0]        in_last_index = '0;
  logic signed [rmps_pkg::VAL_W-1:0] in_new_value = '0;
  logic                              out_valid;
  logic [rmps_pkg::OUT_W-1:0]        out_best_prefix;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [rmps_pkg::IDX_W-1:0]        cfg_used_length = rmps_pkg::LEN_RESET;

  // predictor state: element values and prefix sums, index 0 stays zero
  longint                     elem_val [0:rmps_pkg::DEPTH];
  longint                     prefix_sum [0:rmps_pkg::DEPTH];
  logic [rmps_pkg::IDX_W-1:0] used_len;
  logic [rmps_pkg::OUT_W-1:0] best_q [$];
  bit                         row_known = 1'b0;
  logic [rmps_pkg::OUT_W-1:0] row_best = '0;
  int                         mismatches = 0;
  int                         gap_pct = 0;

  range_max_prefix_sum_table_top uut (.*);

  always #6 clk = ~clk;

  function automatic int eff_len();
    return (used_len < rmps_pkg::LEN_MAX) ? int'(used_len) : rmps_pkg::DEPTH;
  endfunction

  function automatic void store_element(int pos, logic signed [rmps_pkg::VAL_W-1:0] v);
    int     len;
    longint d;
    len = eff_len();
    if (pos == 0 || pos > len) return;
    d = longint'(v) - elem_val[pos];
    elem_val[pos] = longint'(v);
    for (int k = pos; k <= len; k++) prefix_sum[k] += d;
  endfunction

  function automatic logic [rmps_pkg::OUT_W-1:0] best_range_sum(int a, int b);
    int     len;
    longint top;
    len = eff_len();
    if (a == 0) a = 1;
    if (b > len) b = len;
    if (len == 0 || a > b) return '0;
    top = prefix_sum[a];
    for (int k = a + 1; k <= b; k++) if (prefix_sum[k] > top) top = prefix_sum[k];
    top -= prefix_sum[a-1];
    if (top <= 0) return '0;
    if (top > longint'(BEST_SAT)) return BEST_SAT;
    return rmps_pkg::OUT_W'(top);
  endfunction

  // prediction and checking share one process so an answer given in the
  // accepting cycle finds its expectation already queued
  always @(posedge clk) begin
    logic [rmps_pkg::OUT_W-1:0] want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) used_len = cfg_used_length;
      if (start && !busy) begin
        if (in_opcode == rmps_pkg::OP_QUERY) begin
          want = best_range_sum(int'(in_first_index), int'(in_last_index));
          best_q = {best_q, (row_known ? row_best : want)};
        end else
          store_element(int'(in_first_index), in_new_value);
      end
      if (out_valid) begin
        if (best_q.size() == 0) begin
          $error("best_prefix: none expected, got %0d", out_best_prefix);
          mismatches++;
        end else begin
          want = best_q.pop_front();
          if (out_best_prefix !== want) begin
            $error("best_prefix: expected %0d, got %0d", want, out_best_prefix);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic issue(input stim_row_t r);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    start          <= 1'b1;
    in_opcode      <= r.op;
    in_first_index <= r.first;
    in_last_index  <= r.last;
    in_new_value   <= r.value;
    row_known      = r.known;
    row_best       = r.best;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    wait (best_q.size() == 0);
    @(negedge clk);
    while (busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_length(input logic [rmps_pkg::IDX_W-1:0] v);
    drain();
    cfg_valid       <= 1'b1;
    cfg_used_length <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic stim_row_t random_row(int len);
    stim_row_t r;
    int        span;
    span    = (len == 0) ? 1 : len;
    r.known = 1'b0;
    r.best  = '0;
    r.op    = ($urandom_range(99) < 55) ? rmps_pkg::OP_WRITE : rmps_pkg::OP_QUERY;
    r.first = ($urandom_range(9) == 0) ? rmps_pkg::IDX_W'($urandom_range(2047))
                                       : rmps_pkg::IDX_W'($urandom_range(span, 1));
    r.last  = ($urandom_range(9) == 0) ? rmps_pkg::IDX_W'($urandom_range(2047))
                                       : rmps_pkg::IDX_W'($urandom_range(span, r.first));
    case ($urandom_range(3))
      0:       r.value = $urandom;
      1:       r.value = $urandom_range(1, 0) ? 32'h7fff_ffff : 32'h8000_0000;
      default: r.value = rmps_pkg::VAL_W'($signed($urandom_range(2000)) - 1000);
    endcase
    return r;
  endfunction

  stim_row_t directed [] = '{
    '{rmps_pkg::OP_QUERY, 11'd1,    11'd1024, 32'd0,          1'b1, 41'd0},
    '{rmps_pkg::OP_QUERY, 11'd0,    11'd5,    32'd0,          1'b1, 41'd0},
    '{rmps_pkg::OP_QUERY, 11'd10,   11'd5,    32'd0,          1'b1, 41'd0},
    '{rmps_pkg::OP_WRITE, 11'd0,    11'd0,    32'h7fff_ffff,  1'b0, 41'd0},
    '{rmps_pkg::OP_WRITE, 11'd1025, 11'd0,    32'h7fff_ffff,  1'b0, 41'd0},
    '{rmps_pkg::OP_WRITE, 11'd2047, 11'd2047, 32'hffff_ffff,  1'b0, 41'd0},
    '{rmps_pkg::OP_WRITE, 11'd1,    11'd0,    32'h7fff_ffff,  1'b0, 41'd0},
    '{rmps_pkg::OP_WRITE, 11'd1024, 11'd0,    32'h8000_0000,  1'b0, 41'd0},
    '{rmps_pkg::OP_QUERY, 11'd1,    11'd1,    32'd0,          1'b1, 41'd2147483647},
    '{rmps_pkg::OP_WRITE, 11'd2,    11'd0,    32'h7fff_ffff,  1'b0, 41'd0},
    '{rmps_pkg::OP_QUERY, 11'd1,    11'd2,    32'd0,          1'b1, 41'd4294967294},
    '{rmps_pkg::OP_QUERY, 11'd1,    11'd2047, 32'd0,          1'b0, 41'd0},
    '{rmps_pkg::OP_QUERY, 11'd2,    11'd2,    32'd0,          1'b1, 41'd2147483647},
    '{rmps_pkg::OP_QUERY, 11'd1024, 11'd1024, 32'd0,          1'b1, 41'd0},
    '{rmps_pkg::OP_WRITE, 11'd2,    11'd0,    32'h7fff_ffff,  1'b0, 41'd0},
    '{rmps_pkg::OP_WRITE, 11'd1,    11'd0,    32'h8000_0000,  1'b0, 41'd0},
    '{rmps_pkg::OP_QUERY, 11'd1,    11'd1,    32'd0,          1'b1, 41'd0},
    '{rmps_pkg::OP_QUERY, 11'd0,    11'd1024, 32'hffff_ffff,  1'b0, 41'd0},
    '{rmps_pkg::OP_QUERY, 11'd2047, 11'd2047, 32'd0,          1'b1, 41'd0},
    '{rmps_pkg::OP_WRITE, 11'd1023, 11'd0,    32'h0000_0005,  1'b0, 41'd0},
    '{rmps_pkg::OP_QUERY, 11'd1023, 11'd1024, 32'd0,          1'b0, 41'd0}
  };

  // used length, item count, percent chance of an idle gap before each item
  int phase_len [] = '{16, 64, 1, 0, 200, 5, 1024, 2047, 33};
  int phase_cnt [] = '{300, 280, 60, 40, 220, 200, 50, 40, 100};
  int phase_gap [] = '{0, 85, 17, 0, 17, 85, 0, 85, 17};

  initial begin
    for (int k = 0; k <= rmps_pkg::DEPTH; k++) begin
      elem_val[k]   = 0;
      prefix_sum[k] = 0;
    end
    used_len = rmps_pkg::LEN_RESET;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) issue(directed[i]);
    row_known = 1'b0;

    foreach (phase_len[p]) begin
      set_length(rmps_pkg::IDX_W'(phase_len[p]));
      gap_pct = phase_gap[p];
      for (int i = 0; i < phase_cnt[p]; i++) begin
        // in the second phase, hold off once midway until every answer is in
        if (p == 1 && i == phase_cnt[p] / 2) begin
          start <= 1'b0;
          wait (best_q.size() == 0);
          @(negedge clk);
        end
        issue(random_row(phase_len[p] < rmps_pkg::DEPTH ? phase_len[p] : rmps_pkg::DEPTH));
      end
    end

    start <= 1'b0;
    wait (best_q.size() == 0);
    repeat (1100) @(posedge clk);
    if (mismatches == 0)
      $display("range_max_prefix_sum_table_top: match");
    else
      $display("range_max_prefix_sum_table_top: mismatch");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("range_max_prefix_sum_table_top: mismatch");
    $finish;
  end

endmodule
